// ----- rtl/tlin_pkg.sv -----
// Package for the thermistor temperature linearizer.
// Holds widths, pipeline depth, register indexes and the resistance/temperature ROM.
`timescale 1ns / 1ps
package tlin_pkg;

	localparam int TABLE_POINTS = 20;
	localparam int SEG_W = $clog2(TABLE_POINTS - 1);

	localparam int V_W = 13;
	localparam int SER_W = 16;
	localparam int SUP_W = 13;
	localparam int NUM_W = SER_W + V_W;
	localparam int RT_W = 17;
	localparam int RES_W = 17;
	localparam int TMP_W = 8;

	localparam int DIV_STEP = 4;
	localparam int DIV_ST = (RT_W + DIV_STEP - 1) / DIV_STEP;

	localparam int N_W = 25;
	localparam int Q_W = 7;
	localparam int QSPLIT = 4;

	// S1, division stages, lookup, operand fetch, products, two quotient stages, output
	localparam int NST = DIV_ST + 7;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SERIES_OHMS = 2'd0,
		REG_SUPPLY_MV   = 2'd1
	} cfg_reg_t;

	localparam logic [SER_W-1:0] SERIES_RST = SER_W'(1000);
	localparam logic [SUP_W-1:0] SUPPLY_RST = SUP_W'(5000);

	typedef logic [RES_W-1:0] res_t;
	typedef logic signed [TMP_W-1:0] temp_t;

	localparam res_t RES_ROM [TABLE_POINTS] = '{
		res_t'(177),   res_t'(241),   res_t'(332),   res_t'(467),   res_t'(667),
		res_t'(973),   res_t'(1188),  res_t'(1459),  res_t'(1802),  res_t'(2238),
		res_t'(2796),  res_t'(3520),  res_t'(4450),  res_t'(5670),  res_t'(7280),
		res_t'(9420),  res_t'(16180), res_t'(28680), res_t'(52700), res_t'(100000)
	};

	localparam temp_t TMP_ROM [TABLE_POINTS] = '{
		temp_t'(100), temp_t'(90),  temp_t'(80),  temp_t'(70),  temp_t'(60),
		temp_t'(50),  temp_t'(45),  temp_t'(40),  temp_t'(35),  temp_t'(30),
		temp_t'(25),  temp_t'(20),  temp_t'(15),  temp_t'(10),  temp_t'(5),
		temp_t'(0),   temp_t'(-10), temp_t'(-20), temp_t'(-30), temp_t'(-40)
	};

endpackage

// ----- rtl/tlin_if.sv -----
// Channel interfaces for the thermistor temperature linearizer.
// Depends on tlin_pkg for field widths.
`timescale 1ns / 1ps
interface tlin_in_if;
	logic                        valid;
	logic                        ready;
	logic [tlin_pkg::V_W-1:0]    voltage_mv;
	modport source (output valid, output voltage_mv, input ready);
	modport sink (input valid, input voltage_mv, output ready);
endinterface

interface tlin_out_if;
	logic                        valid;
	logic                        ready;
	logic signed [tlin_pkg::TMP_W-1:0] temperature_c;
	logic                        out_of_range;
	modport source (output valid, output temperature_c, output out_of_range, input ready);
	modport sink (input valid, input temperature_c, input out_of_range, output ready);
endinterface

interface tlin_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tlin_pkg::CFG_IDX_W-1:0]   index;
	logic [tlin_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/thermistor_temperature_linearizer.sv -----
// Thermistor temperature linearizer, top level.
// Depends on tlin_pkg and the channel interfaces in tlin_if.sv.
//
// Usage:
//   din  carries one divider voltage sample (voltage_mv) per transaction.
//   dout carries one result per sample: temperature_c and out_of_range.
//   cfg  writes series_ohms (index 0) and supply_mv (index 1); other indexes
//        are dropped. cfg.ready is always high. Write only while idle.
// Throughput: one sample per cycle while dout takes results. The pipeline
//   holds the resistance divider (five stages of up to four quotient bits),
//   the table lookup, the interpolation products and a two-stage quotient by
//   the segment width.
// Stall: every stage holds only while the stage after it is full and
//   stalled, so bubbles close up and din.ready drops only when all twelve
//   stages hold data and dout is not taken. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits and loads series_ohms = 1000 and
//   supply_mv = 5000.
`timescale 1ns / 1ps
module thermistor_temperature_linearizer (
	input  logic clk,
	input  logic arst_n,
	tlin_in_if.sink    din,
	tlin_out_if.source dout,
	tlin_cfg_if.sink   cfg
);

	localparam int NST = tlin_pkg::NST;
	localparam int NUM_W = tlin_pkg::NUM_W;
	localparam int RT_W = tlin_pkg::RT_W;
	localparam int SUP_W = tlin_pkg::SUP_W;
	localparam int DIV_ST = tlin_pkg::DIV_ST;
	localparam int DIV_STEP = tlin_pkg::DIV_STEP;
	localparam int RES_W = tlin_pkg::RES_W;
	localparam int SEG_W = tlin_pkg::SEG_W;
	localparam int N_W = tlin_pkg::N_W;
	localparam int Q_W = tlin_pkg::Q_W;
	localparam int QSPLIT = tlin_pkg::QSPLIT;
	localparam int TP = tlin_pkg::TABLE_POINTS;

	logic [tlin_pkg::SER_W-1:0] series_q;
	logic [SUP_W-1:0]           supply_q;

	logic vld [NST];
	logic en  [NST+1];

	// pipeline data
	logic [NUM_W-1:0] drem_s [DIV_ST+1];
	logic [RT_W-1:0]  dquo_s [DIV_ST+1];
	logic [SUP_W-1:0] dden_s [DIV_ST+1];
	logic             dok_s  [DIV_ST+1];
	logic             dovr_s [DIV_ST+1];

	logic [NUM_W-1:0] nrem [DIV_ST+1];
	logic [RT_W-1:0]  nquo [DIV_ST+1];
	logic             ovr_n;

	logic [RT_W-1:0]  rt_s7;
	logic [SEG_W-1:0] seg_s7;
	logic             ok_s7;

	logic [RES_W-1:0]       dx_s8;
	logic [RES_W-1:0]       off_s8;
	tlin_pkg::temp_t        y1_s8;
	tlin_pkg::temp_t        dy_s8;
	logic                   ok_s8;

	logic signed [N_W-1:0]  n_s9;
	logic [RES_W-1:0]       dx_s9;
	logic                   ok_s9;

	logic [N_W-2:0]   qr_s10;
	logic [Q_W-1:0]   qq_s10;
	logic [RES_W-1:0] dx_s10;
	logic             neg_s10;
	logic             ok_s10;

	logic [Q_W-1:0]   qq_s11;
	logic             neg_s11;
	logic             ok_s11;

	tlin_pkg::temp_t  temp_s12;
	logic             oor_s12;

	// combinational stage results
	logic [RT_W-1:0]  rt_c;
	logic             inr_c;
	logic [SEG_W-1:0] seg_c;
	logic [SEG_W-1:0] seg_nx;
	logic signed [N_W-1:0] n_c;
	logic [N_W-2:0]   mag_c;
	logic [N_W-2:0]   qr_c;
	logic [Q_W-1:0]   qq_c;
	logic [N_W-2:0]   qr2_c;
	logic [Q_W-1:0]   qq2_c;
	logic [N_W-2:0]   sh_c;
	logic [N_W-2:0]   sh2_c;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= tlin_pkg::SERIES_RST;
			supply_q <= tlin_pkg::SUPPLY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				tlin_pkg::REG_SERIES_OHMS: series_q <= cfg.data[tlin_pkg::SER_W-1:0];
				tlin_pkg::REG_SUPPLY_MV:   supply_q <= cfg.data[SUP_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when the next one advances
	always_comb begin
		en[NST] = dout.ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign din.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) begin
				vld[k] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				vld[0] <= din.valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// resistance divider: up to four quotient bits per stage
	always_comb begin
		logic [NUM_W-1:0] r;
		logic [RT_W-1:0]  q;
		logic [NUM_W:0]   sh;
		int               b;
		nrem[0] = drem_s[0];
		nquo[0] = dquo_s[0];
		ovr_n = {1'b0, drem_s[0]} >= ((NUM_W+1)'(dden_s[0]) << RT_W);
		for (int k = 1; k <= DIV_ST; k++) begin
			r = drem_s[k-1];
			q = dquo_s[k-1];
			for (int j = 0; j < DIV_STEP; j++) begin
				b = RT_W - 1 - (k - 1) * DIV_STEP - j;
				if (b >= 0) begin
					sh = (NUM_W+1)'(dden_s[k-1]) << b;
					if ({1'b0, r} >= sh) begin
						r = r - sh[NUM_W-1:0];
						q[b] = 1'b1;
					end
				end
			end
			nrem[k] = r;
			nquo[k] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			drem_s[0] <= NUM_W'(series_q) * NUM_W'(din.voltage_mv);
			dden_s[0] <= supply_q - din.voltage_mv;
			dquo_s[0] <= '0;
			dok_s[0]  <= din.voltage_mv < supply_q;
			dovr_s[0] <= 1'b0;
		end
		for (int k = 1; k <= DIV_ST; k++) begin
			if (en[k]) begin
				drem_s[k] <= nrem[k];
				dquo_s[k] <= nquo[k];
				dden_s[k] <= dden_s[k-1];
				dok_s[k]  <= dok_s[k-1];
				dovr_s[k] <= dovr_s[k-1] | ((k == 1) && ovr_n);
			end
		end
	end

	// segment search
	always_comb begin
		rt_c = dquo_s[DIV_ST];
		inr_c = dok_s[DIV_ST] && !dovr_s[DIV_ST] && (rt_c > tlin_pkg::RES_ROM[0]) &&
			(rt_c <= tlin_pkg::RES_ROM[TP-1]);
		seg_c = '0;
		for (int j = 1; j < TP - 1; j++) begin
			seg_c = seg_c + SEG_W'(tlin_pkg::RES_ROM[j] < rt_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_ST+1]) begin
			rt_s7  <= rt_c;
			seg_s7 <= seg_c;
			ok_s7  <= inr_c;
		end
	end

	// operand fetch
	assign seg_nx = seg_s7 + SEG_W'(1);

	always_ff @(posedge clk) begin
		if (en[DIV_ST+2]) begin
			dx_s8  <= tlin_pkg::RES_ROM[seg_nx] - tlin_pkg::RES_ROM[seg_s7];
			off_s8 <= rt_s7 - tlin_pkg::RES_ROM[seg_s7];
			y1_s8  <= tlin_pkg::TMP_ROM[seg_s7];
			dy_s8  <= tlin_pkg::TMP_ROM[seg_nx] - tlin_pkg::TMP_ROM[seg_s7];
			ok_s8  <= ok_s7;
		end
	end

	// interpolation numerator
	assign n_c = N_W'(y1_s8) * $signed(N_W'(dx_s8)) + N_W'(dy_s8) * $signed(N_W'(off_s8));

	always_ff @(posedge clk) begin
		if (en[DIV_ST+3]) begin
			n_s9  <= n_c;
			dx_s9 <= dx_s8;
			ok_s9 <= ok_s8;
		end
	end

	// quotient by segment width, upper bits then lower bits
	always_comb begin
		mag_c = n_s9[N_W-1] ? (N_W-1)'(-n_s9) : n_s9[N_W-2:0];
		qr_c = mag_c;
		qq_c = '0;
		sh_c = '0;
		for (int b = Q_W - 1; b >= Q_W - QSPLIT; b--) begin
			sh_c = (N_W-1)'(dx_s9) << b;
			if (qr_c >= sh_c) begin
				qr_c = qr_c - sh_c;
				qq_c[b] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_ST+4]) begin
			qr_s10  <= qr_c;
			qq_s10  <= qq_c;
			dx_s10  <= dx_s9;
			neg_s10 <= n_s9[N_W-1];
			ok_s10  <= ok_s9;
		end
	end

	always_comb begin
		qr2_c = qr_s10;
		qq2_c = qq_s10;
		sh2_c = '0;
		for (int b = Q_W - QSPLIT - 1; b >= 0; b--) begin
			sh2_c = (N_W-1)'(dx_s10) << b;
			if (qr2_c >= sh2_c) begin
				qr2_c = qr2_c - sh2_c;
				qq2_c[b] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_ST+5]) begin
			qq_s11  <= qq2_c;
			neg_s11 <= neg_s10;
			ok_s11  <= ok_s10;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en[DIV_ST+6]) begin
			if (!ok_s11) begin
				temp_s12 <= '0;
			end else if (neg_s11) begin
				temp_s12 <= -tlin_pkg::temp_t'(qq_s11);
			end else begin
				temp_s12 <= tlin_pkg::temp_t'(qq_s11);
			end
			oor_s12 <= !ok_s11;
		end
	end

	assign dout.valid = vld[NST-1];
	assign dout.temperature_c = temp_s12;
	assign dout.out_of_range = oor_s12;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.out_of_range |-> dout.temperature_c == '0)
		else $error("out-of-range result with nonzero temperature");

	a_temp_span: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.out_of_range |->
			$signed(dout.temperature_c) >= -40 && $signed(dout.temperature_c) <= 100)
		else $error("temperature outside table span");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> vld[0] && vld[NST-1] && !dout.ready)
		else $error("input stalled while pipeline can advance");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.ready |=> dout.valid && $stable(temp_s12) && $stable(oor_s12))
		else $error("held result changed under stall");

endmodule
